// File: design/text_mode_terminal_writer_macros.svh
// ----------------------------------------------------------------------------
// Text-mode terminal writer: assertion macros
// Shorthand for the concurrent checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef TEXT_MODE_TERMINAL_WRITER_MACROS_SVH
`define TEXT_MODE_TERMINAL_WRITER_MACROS_SVH

// same-cycle implication, off while reset is high
`define TMTW_ASSERT_IMPLY(label, clk, rst, cond, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
      else $error(msg);

// next-cycle implication, off while reset is high
`define TMTW_ASSERT_NEXT(label, clk, rst, cond, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error(msg);

`endif

// File: design/tmtw_pkg.sv
// ----------------------------------------------------------------------------
// Text-mode terminal writer: package
// Field widths, command codes, character codes and the control/status
// structures shared between controller and datapath.
// ----------------------------------------------------------------------------
package tmtw_pkg;

   localparam int DEF_COLUMNS = 80;
   localparam int DEF_ROWS    = 25;

   localparam int CMD_W       = 2;
   localparam int CHAR_W      = 8;
   localparam int ATTR_W      = 8;
   localparam int CELL_W      = 16;
   localparam int ROW_FIELD_W = 5;
   localparam int COL_FIELD_W = 7;
   localparam int REQ_TDATA_W = 24;
   localparam int RSP_TDATA_W = 32;

   localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'h0A;
   localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'h08;
   localparam logic [CHAR_W-1:0] CH_BLANK     = 8'h20;
   localparam logic [ATTR_W-1:0] RESET_COLOR  = 8'h07;

   typedef enum logic [CMD_W-1:0] {
      OP_PUT   = 2'd0,
      OP_READ  = 2'd1,
      OP_CLEAR = 2'd2,
      OP_NONE  = 2'd3
   } op_type;

   typedef struct packed {
      logic accept;    // request transaction taken this cycle
      logic walk;      // write one cell of a screen sweep
      logic copy;      // sweep moves rows up instead of blanking
      logic init;      // sweep blanks in the reset colour
      logic rsp_load;  // load the response register
      logic rsp_cell;  // response carries the cell read last cycle
   } ctrl_cmd_type;

   typedef struct packed {
      logic op_read;
      logic op_clear;
      logic scroll;     // request would push the cursor past the bottom row
      logic walk_last;  // sweep is at the last cell
   } dp_status_type;

endpackage

// File: design/tmtw_ctrl.sv
// ----------------------------------------------------------------------------
// Text-mode terminal writer: controller
// Sequences reset blanking, reads, clears and scrolls, and owns both
// handshakes.
// ----------------------------------------------------------------------------
module tmtw_ctrl import tmtw_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   input  dp_status_type status,
   output ctrl_cmd_type  cmd
);

   typedef enum logic [4:0] {
      ST_INIT   = 5'b00001,
      ST_IDLE   = 5'b00010,
      ST_READ   = 5'b00100,
      ST_CLEAR  = 5'b01000,
      ST_SCROLL = 5'b10000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_comb begin
      cmd        = '0;
      state_in   = state_ff;
      req_tready = 1'b0;
      unique case (state_ff)
         ST_INIT: begin
            cmd.walk = 1'b1;
            cmd.init = 1'b1;
            if (status.walk_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            // take a new transaction once the response register is free or draining
            req_tready = !rsp_valid_ff || rsp_tready;
            cmd.accept = req_tready && req_tvalid;
            if (cmd.accept) begin
               priority if (status.op_read) begin
                  state_in = ST_READ;
               end else if (status.op_clear) begin
                  state_in = ST_CLEAR;
               end else if (status.scroll) begin
                  state_in = ST_SCROLL;
               end else begin
                  cmd.rsp_load = 1'b1;
               end
            end
         end
         ST_READ: begin
            cmd.rsp_load = 1'b1;
            cmd.rsp_cell = 1'b1;
            state_in     = ST_IDLE;
         end
         ST_CLEAR: begin
            cmd.walk = 1'b1;
            if (status.walk_last) begin
               cmd.rsp_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         ST_SCROLL: begin
            cmd.walk = 1'b1;
            cmd.copy = 1'b1;
            if (status.walk_last) begin
               cmd.rsp_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_INIT;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.rsp_load) rsp_valid_in = 1'b1;
      else if (rsp_tready) rsp_valid_in = 1'b0;
   end

   assign rsp_tvalid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// File: design/tmtw_datapath.sv
// ----------------------------------------------------------------------------
// Text-mode terminal writer: datapath
// Screen store, cursor, colour register, sweep counter and response
// register.
// ----------------------------------------------------------------------------
module tmtw_datapath import tmtw_pkg::*; #(
   parameter int COLUMNS = DEF_COLUMNS,
   parameter int ROWS    = DEF_ROWS
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_wr_en,
   input  logic [ATTR_W-1:0]      csr_wr_data,
   input  logic [CMD_W-1:0]       command,
   input  logic [CHAR_W-1:0]      char_code,
   input  logic [ROW_FIELD_W-1:0] read_row,
   input  logic [COL_FIELD_W-1:0] read_col,
   input  ctrl_cmd_type           cmd,
   output dp_status_type          status,
   output logic [CELL_W-1:0]      cell_value,
   output logic [ROW_FIELD_W-1:0] cursor_row,
   output logic [COL_FIELD_W-1:0] cursor_col
);

   localparam int CELLS  = ROWS * COLUMNS;
   localparam int ADDR_W = $clog2(CELLS);
   localparam int ROW_W  = $clog2(ROWS);
   localparam int COL_W  = $clog2(COLUMNS);

   localparam logic [ADDR_W-1:0] LAST_ADDR  = ADDR_W'(CELLS - 1);
   localparam logic [ADDR_W-1:0] COPY_END   = ADDR_W'(CELLS - COLUMNS);
   localparam logic [ADDR_W-1:0] COPY_LAST  = ADDR_W'(CELLS - COLUMNS - 1);
   localparam logic [ADDR_W-1:0] ROW_STRIDE = ADDR_W'(COLUMNS);
   localparam logic [ROW_W-1:0]  LAST_ROW   = ROW_W'(ROWS - 1);
   localparam logic [COL_W-1:0]  LAST_COL   = COL_W'(COLUMNS - 1);

   logic [ATTR_W-1:0] color_ff, color_in;
   logic [ROW_W-1:0]  row_ff, row_in;
   logic [COL_W-1:0]  col_ff, col_in;
   logic [ADDR_W-1:0] walk_ff, walk_in;
   logic              rd_ok_ff, rd_ok_in;

   logic [CELL_W-1:0] screen_mem [CELLS];
   logic [CELL_W-1:0] mem_q_ff;
   logic [CELL_W-1:0] cell_ff;
   logic [ROW_W-1:0]  row_out_ff;
   logic [COL_W-1:0]  col_out_ff;

   op_type            op;
   logic              is_nl, is_bs, col_wrap, row_last, adv_row, in_range;
   logic [ADDR_W-1:0] cur_addr, req_addr, rd_addr, wr_addr;
   logic [CELL_W-1:0] wr_data;
   logic [ATTR_W-1:0] blank_attr;
   logic              rd_en, wr_en;

   assign op         = op_type'(command);
   assign is_nl      = char_code == CH_NEWLINE;
   assign is_bs      = char_code == CH_BACKSPACE;
   assign col_wrap   = col_ff == LAST_COL;
   assign row_last   = row_ff == LAST_ROW;
   assign adv_row    = (op == OP_PUT) && (is_nl || (!is_bs && col_wrap));
   assign in_range   = (32'(read_row) < ROWS) && (32'(read_col) < COLUMNS);
   assign cur_addr   = ADDR_W'(32'(row_ff) * COLUMNS + 32'(col_ff));
   assign req_addr   = ADDR_W'(32'(read_row) * COLUMNS + 32'(read_col));
   assign blank_attr = cmd.init ? RESET_COLOR : color_ff;

   assign status.op_read   = op == OP_READ;
   assign status.op_clear  = op == OP_CLEAR;
   assign status.scroll    = adv_row && row_last;
   assign status.walk_last = walk_ff == LAST_ADDR;

   // cursor update, the single-cell write of put-character and the sweep write
   always_comb begin
      row_in  = row_ff;
      col_in  = col_ff;
      wr_en   = 1'b0;
      wr_addr = cur_addr;
      wr_data = {color_ff, char_code};
      unique case (op)
         OP_PUT: begin
            if (is_nl) begin
               col_in = '0;
            end else if (is_bs) begin
               if (col_ff != '0) begin
                  col_in  = col_ff - 1'b1;
                  wr_en   = cmd.accept;
                  wr_addr = cur_addr - 1'b1;
                  wr_data = {color_ff, CH_BLANK};
               end
            end else begin
               wr_en  = cmd.accept;
               col_in = col_wrap ? '0 : col_ff + 1'b1;
            end
            // bottom row stays put; the sweep scrolls the text instead
            if (adv_row && !row_last) row_in = row_ff + 1'b1;
         end
         OP_CLEAR: begin
            row_in = '0;
            col_in = '0;
         end
         OP_READ: begin
         end
         OP_NONE: begin
         end
      endcase
      if (cmd.walk) begin
         wr_en   = 1'b1;
         wr_addr = walk_ff;
         wr_data = (cmd.copy && walk_ff < COPY_END) ? mem_q_ff : {blank_attr, CH_BLANK};
      end
   end

   // read port: cell reads, and one row ahead of the write during a scroll
   always_comb begin
      rd_en   = 1'b0;
      rd_addr = req_addr;
      if (cmd.accept && op == OP_READ) begin
         rd_en = in_range;
      end else if (cmd.accept && status.scroll) begin
         rd_en   = 1'b1;
         rd_addr = ROW_STRIDE;
      end else if (cmd.walk && cmd.copy && walk_ff < COPY_LAST) begin
         rd_en   = 1'b1;
         rd_addr = walk_ff + ROW_STRIDE + 1'b1;
      end
   end

   always_comb begin
      color_in = csr_wr_en ? csr_wr_data : color_ff;
      walk_in  = walk_ff;
      if (cmd.walk) walk_in = status.walk_last ? '0 : walk_ff + 1'b1;
      rd_ok_in = rd_ok_ff;
      if (cmd.accept) rd_ok_in = (op == OP_READ) && in_range;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         color_ff <= RESET_COLOR;
         row_ff   <= '0;
         col_ff   <= '0;
         walk_ff  <= '0;
         rd_ok_ff <= 1'b0;
      end else begin
         color_ff <= color_in;
         walk_ff  <= walk_in;
         rd_ok_ff <= rd_ok_in;
         if (cmd.accept) begin
            row_ff <= row_in;
            col_ff <= col_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) screen_mem[wr_addr] <= wr_data;
      if (rd_en) mem_q_ff <= screen_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         cell_ff    <= (cmd.rsp_cell && rd_ok_ff) ? mem_q_ff : '0;
         row_out_ff <= cmd.accept ? row_in : row_ff;
         col_out_ff <= cmd.accept ? col_in : col_ff;
      end
   end

   assign cell_value = cell_ff;
   assign cursor_row = ROW_FIELD_W'(row_out_ff);
   assign cursor_col = COL_FIELD_W'(col_out_ff);

endmodule

// File: design/text_mode_terminal_writer.sv
// ----------------------------------------------------------------------------
// Text-mode terminal writer
// Screen of character cells with a cursor: put-character, read-cell and
// clear commands, scrolling at the bottom row.
// ----------------------------------------------------------------------------
//  Channel  Direction  Carries
//  req_     in         tuser: command; tdata: char_code, read_row, read_col
//  rsp_     out        tdata: cell_value, cursor_row, cursor_col
//  csr_     in         text_color write, no read-back
//
//  Put-character without scroll and unused commands load the response register
//  as they are taken; read-cell goes through the registered screen store read.
//  Clear and scroll sweep the screen, one cell written per cycle by the sweep
//  counter on the single write port. After reset a blanking pass over all
//  ROWS*COLUMNS cells (2000 by default) runs before the first request is taken.
//  A new request is taken while the response register is empty or being drained.
// ----------------------------------------------------------------------------
`include "text_mode_terminal_writer_macros.svh"

module text_mode_terminal_writer import tmtw_pkg::*; #(
   parameter int COLUMNS = DEF_COLUMNS,
   parameter int ROWS    = DEF_ROWS
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_wr_en,
   input  logic [ATTR_W-1:0]      csr_wr_data,  // text_color
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,    // char_code, read_row, read_col, zero pad
   input  logic [CMD_W-1:0]       req_tuser,    // command
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata     // cell_value, cursor_row, cursor_col, zero pad
);

   ctrl_cmd_type           cmd;
   dp_status_type          status;
   logic [CELL_W-1:0]      cell_value;
   logic [ROW_FIELD_W-1:0] cursor_row;
   logic [COL_FIELD_W-1:0] cursor_col;

   tmtw_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   tmtw_datapath #(
      .COLUMNS (COLUMNS),
      .ROWS    (ROWS)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .command     (req_tuser),
      .char_code   (req_tdata[7:0]),
      .read_row    (req_tdata[12:8]),
      .read_col    (req_tdata[19:13]),
      .cmd         (cmd),
      .status      (status),
      .cell_value  (cell_value),
      .cursor_row  (cursor_row),
      .cursor_col  (cursor_col)
   );

   assign rsp_tdata = RSP_TDATA_W'({cursor_col, cursor_row, cell_value});

   `TMTW_ASSERT_IMPLY(a_sweep_blocks_input, clock, reset, cmd.walk, !req_tready, "request taken during screen sweep")
   `TMTW_ASSERT_IMPLY(a_rsp_no_overwrite, clock, reset, cmd.rsp_load, (!rsp_tvalid || rsp_tready), "response register overwritten while full")
   `TMTW_ASSERT_IMPLY(a_cursor_on_screen, clock, reset, rsp_tvalid, ((32'(rsp_tdata[20:16]) < ROWS) && (32'(rsp_tdata[27:21]) < COLUMNS)), "reported cursor off the screen")
   `TMTW_ASSERT_NEXT(a_read_one_cycle, clock, reset, (req_tvalid && req_tready && status.op_read), (cmd.rsp_load && cmd.rsp_cell), "read response not loaded on the next cycle")

endmodule
